/* rtl/qwsc_pkg.sv */
// Shared constants, types and the quarter-wave sine table builder.
`timescale 1ns / 1ps
package qwsc_pkg;

  // Table and sample sizing
  localparam int TABLE_DEPTH = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int FULL_TURN   = 4 * TABLE_DEPTH;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ANGLE_W     = $clog2(FULL_TURN);
  localparam int QUAD_W      = 3;
  localparam int GAIN_W      = SAMPLE_W - 1;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int SUM_W       = 2 * SAMPLE_W + 1;
  localparam int AMP_MAX     = (1 << (SAMPLE_W - 1)) - 1;

  // Stream widths, padded to whole bytes
  localparam int S_TDATA_W   = ((ANGLE_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 8 * SAMPLE_W + QUAD_W;
  localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT3_HALF_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_GAIN       = 1'd1;
  localparam logic [GAIN_W-1:0] ROOT3_HALF_GAIN_RESET  = GAIN_W'(28378);
  localparam logic [GAIN_W-1:0] HALF_GAIN_RESET        = GAIN_W'(16384);

  // Fixed-point pi in Q30 and the Taylor series denominators (2k)(2k+1)
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TermDen [1:10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                             64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0] rom_t [TABLE_DEPTH];

  // Folded table indexes and sign flips for one angle
  typedef struct packed {
    logic [IDX_W-1:0] idx_s;
    logic [IDX_W-1:0] idx_c;
    logic             neg_s;
    logic             neg_c;
  } fold_t;

  // Sign flips and quadrant that travel alongside the table reads
  typedef struct packed {
    logic              neg_s_a;
    logic              neg_c_a;
    logic              neg_s_t;
    logic              neg_c_t;
    logic [QUAD_W-1:0] quad;
  } flags_t;

  // Stage enables of the arithmetic back end
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // One table entry: sine of the bin centre, evaluated by an integer series
  function automatic sample_t rom_entry(int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'(2 * i + 1) * PI_Q30) / FULL_TURN;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / TermDen[k];
      if (k % 2 == 1) sum = sum - signed'(term);
      else            sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    r = ((64'(sum) << (SAMPLE_W - 1)) + (64'd1 << 29)) >> 30;
    if (r > 64'(AMP_MAX)) r = 64'(AMP_MAX);
    return SAMPLE_W'(r);
  endfunction

  // Whole quarter-wave table, worked out at elaboration
  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < TABLE_DEPTH; i++) t[i] = rom_entry(i);
    return t;
  endfunction

  // Quadrant folding: odd quadrants mirror the index, the upper half negates sine
  function automatic fold_t fold_angle(logic [ANGLE_W-1:0] a);
    logic [IDX_W-1:0] lo;
    logic [1:0]       q;
    fold_t            f;
    lo      = a[IDX_W-1:0];
    q       = a[ANGLE_W-1 -: 2];
    f.idx_s = q[0] ? ~lo : lo;
    f.idx_c = q[0] ? lo : ~lo;
    f.neg_s = q[1];
    f.neg_c = q[1] ^ q[0];
    return f;
  endfunction

endpackage

/* rtl/quarter_wave_sincos_three_phase.sv */
// Top level: three-phase quarter-wave sine and cosine lookup pipeline.
// The pipeline takes one item per cycle while the output side is ready; the five
// register stages (fold, table read, sign restore, gain multiply, round and
// saturate) each hold one item.
// Each stage advances when it is empty or its successor advances.
// Synchronous active-high reset empties the pipeline and restores both gains.
`timescale 1ns / 1ps
module quarter_wave_sincos_three_phase
  import qwsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Angle items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // angle[11:0], zero pad
  // Result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // sin_a, cos_a, sin_b, cos_b, sin_c, cos_c,
                                          // sin_triple, cos_triple (16 each),
                                          // quadrant_triple[130:128], zero pad
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  logic              v1, v2, v3, v4, v5;
  logic              en1, en2;
  pipe_en_t          en_be;
  fold_t             fold_a;
  fold_t             fold_t3;
  logic [QUAD_W-1:0] quad_t3;
  flags_t            flags2;
  sample_t           rom_s_a, rom_c_a, rom_s_t, rom_c_t;
  logic [GAIN_W-1:0] root3_half_gain;
  logic [GAIN_W-1:0] half_gain;
  sample_t           sin_a, cos_a, sin_b, cos_b, sin_c, cos_c;
  sample_t           sin_triple, cos_triple;
  logic [QUAD_W-1:0] quadrant_triple;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root3_half_gain <= ROOT3_HALF_GAIN_RESET;
      half_gain       <= HALF_GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROOT3_HALF_GAIN: root3_half_gain <= cfg_data;
        REG_HALF_GAIN:       half_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or the next one moves
  assign en_be.s5 = !v5 || m_tready;
  assign en_be.s4 = !v4 || en_be.s5;
  assign en_be.s3 = !v3 || en_be.s4;
  assign en2      = !v2 || en_be.s3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  // Valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1)      v1 <= s_tvalid;
      if (en2)      v2 <= v1;
      if (en_be.s3) v3 <= v2;
      if (en_be.s4) v4 <= v3;
      if (en_be.s5) v5 <= v4;
    end
  end

  // Stage 1: folding
  qwsc_fold u_fold (
    .clk     (clk),
    .en      (en1),
    .angle   (s_tdata[ANGLE_W-1:0]),
    .fold_a  (fold_a),
    .fold_t3 (fold_t3),
    .quad_t3 (quad_t3)
  );

  // Stage 2: table reads for the angle and the tripled angle
  qwsc_rom u_rom_a (
    .clk    (clk),
    .en     (en2),
    .addr_s (fold_a.idx_s),
    .addr_c (fold_a.idx_c),
    .dout_s (rom_s_a),
    .dout_c (rom_c_a)
  );

  qwsc_rom u_rom_t (
    .clk    (clk),
    .en     (en2),
    .addr_s (fold_t3.idx_s),
    .addr_c (fold_t3.idx_c),
    .dout_s (rom_s_t),
    .dout_c (rom_c_t)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      flags2.neg_s_a <= fold_a.neg_s;
      flags2.neg_c_a <= fold_a.neg_c;
      flags2.neg_s_t <= fold_t3.neg_s;
      flags2.neg_c_t <= fold_t3.neg_c;
      flags2.quad    <= quad_t3;
    end
  end

  // Stages 3 to 5: signs, products, rounding
  qwsc_rotate u_rotate (
    .clk             (clk),
    .en              (en_be),
    .rom_s_a         (rom_s_a),
    .rom_c_a         (rom_c_a),
    .rom_s_t         (rom_s_t),
    .rom_c_t         (rom_c_t),
    .flags           (flags2),
    .root3_half_gain (root3_half_gain),
    .half_gain       (half_gain),
    .sin_a           (sin_a),
    .cos_a           (cos_a),
    .sin_b           (sin_b),
    .cos_b           (cos_b),
    .sin_c           (sin_c),
    .cos_c           (cos_c),
    .sin_triple      (sin_triple),
    .cos_triple      (cos_triple),
    .quadrant_triple (quadrant_triple)
  );

  assign m_tvalid = v5;
  assign m_tdata  = M_TDATA_W'({quadrant_triple, cos_triple, sin_triple, cos_c, sin_c,
                                cos_b, sin_b, cos_a, sin_a});

endmodule

/* rtl/qwsc_rom.sv */
// Quarter-wave sine ROM with two registered read ports.
`timescale 1ns / 1ps
module qwsc_rom
  import qwsc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] addr_s,
  input  logic [IDX_W-1:0] addr_c,
  output sample_t          dout_s,
  output sample_t          dout_c
);

  localparam rom_t SineTable = build_rom();

  // Synchronous reads, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      dout_s <= SineTable[addr_s];
      dout_c <= SineTable[addr_c];
    end
  end

endmodule

/* rtl/qwsc_fold.sv */
// Angle tripling and quadrant folding into table indexes (first pipeline stage).
`timescale 1ns / 1ps
module qwsc_fold
  import qwsc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [ANGLE_W-1:0] angle,
  output fold_t              fold_a,
  output fold_t              fold_t3,
  output logic [QUAD_W-1:0]  quad_t3
);

  logic [ANGLE_W-1:0] angle_t3;

  // Three times the angle, wrapped to one revolution by truncation
  assign angle_t3 = ANGLE_W'(angle + (angle << 1));

  // Register the folded indexes, sign flips and quadrant of the tripled angle
  always_ff @(posedge clk) begin
    if (en) begin
      fold_a  <= fold_angle(angle);
      fold_t3 <= fold_angle(angle_t3);
      quad_t3 <= QUAD_W'(angle_t3[ANGLE_W-1 -: 2]) + QUAD_W'(1);
    end
  end

endmodule

/* rtl/qwsc_rotate.sv */
// Sign restore, gain products and rounded, saturated rotation sums.
`timescale 1ns / 1ps
module qwsc_rotate
  import qwsc_pkg::*;
(
  input  logic              clk,
  input  pipe_en_t          en,
  input  sample_t           rom_s_a,
  input  sample_t           rom_c_a,
  input  sample_t           rom_s_t,
  input  sample_t           rom_c_t,
  input  flags_t            flags,
  input  logic [GAIN_W-1:0] root3_half_gain,
  input  logic [GAIN_W-1:0] half_gain,
  output sample_t           sin_a,
  output sample_t           cos_a,
  output sample_t           sin_b,
  output sample_t           cos_b,
  output sample_t           sin_c,
  output sample_t           cos_c,
  output sample_t           sin_triple,
  output sample_t           cos_triple,
  output logic [QUAD_W-1:0] quadrant_triple
);

  localparam logic signed [SUM_W-1:0] RoundHalf = SUM_W'(1 << (SAMPLE_W - 2));
  localparam logic signed [SUM_W-1:0] SatHi     = SUM_W'(AMP_MAX);
  localparam logic signed [SUM_W-1:0] SatLo     = -SUM_W'(AMP_MAX);

  // Stage 3 registers
  logic signed [SAMPLE_W-1:0] s3_s;
  logic signed [SAMPLE_W-1:0] s3_c;
  sample_t                    s3_st;
  sample_t                    s3_ct;
  logic [QUAD_W-1:0]          s3_quad;

  // Stage 4 registers
  logic signed [PROD_W-1:0]   rc;
  logic signed [PROD_W-1:0]   hs;
  logic signed [PROD_W-1:0]   hc;
  logic signed [PROD_W-1:0]   rs;
  sample_t                    s4_s;
  sample_t                    s4_c;
  sample_t                    s4_st;
  sample_t                    s4_ct;
  logic [QUAD_W-1:0]          s4_quad;

  logic signed [SAMPLE_W-1:0] r_gain;
  logic signed [SAMPLE_W-1:0] h_gain;
  logic signed [SUM_W-1:0]    sum_sb;
  logic signed [SUM_W-1:0]    sum_cb;
  logic signed [SUM_W-1:0]    sum_sc;
  logic signed [SUM_W-1:0]    sum_cc;

  // Add half an LSB, floor-shift to Q1.15 and clamp symmetrically
  function automatic sample_t round_sat(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    sh = (v + RoundHalf) >>> (SAMPLE_W - 1);
    if (sh > SatHi)      sh = SatHi;
    else if (sh < SatLo) sh = SatLo;
    return SAMPLE_W'(sh);
  endfunction

  // Stage 3: restore signs of the folded table values
  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_s    <= flags.neg_s_a ? -signed'(rom_s_a) : signed'(rom_s_a);
      s3_c    <= flags.neg_c_a ? -signed'(rom_c_a) : signed'(rom_c_a);
      s3_st   <= flags.neg_s_t ? -rom_s_t : rom_s_t;
      s3_ct   <= flags.neg_c_t ? -rom_c_t : rom_c_t;
      s3_quad <= flags.quad;
    end
  end

  assign r_gain = signed'({1'b0, root3_half_gain});
  assign h_gain = signed'({1'b0, half_gain});

  // Stage 4: the four gain products
  always_ff @(posedge clk) begin
    if (en.s4) begin
      rc      <= r_gain * s3_c;
      hs      <= h_gain * s3_s;
      hc      <= h_gain * s3_c;
      rs      <= r_gain * s3_s;
      s4_s    <= s3_s;
      s4_c    <= s3_c;
      s4_st   <= s3_st;
      s4_ct   <= s3_ct;
      s4_quad <= s3_quad;
    end
  end

  // Rotation by +120 and +240 degrees
  assign sum_sb = SUM_W'(rc) - SUM_W'(hs);
  assign sum_cb = -SUM_W'(hc) - SUM_W'(rs);
  assign sum_sc = -SUM_W'(rc) - SUM_W'(hs);
  assign sum_cc = SUM_W'(rs) - SUM_W'(hc);

  // Stage 5: output register
  always_ff @(posedge clk) begin
    if (en.s5) begin
      sin_a           <= s4_s;
      cos_a           <= s4_c;
      sin_b           <= round_sat(sum_sb);
      cos_b           <= round_sat(sum_cb);
      sin_c           <= round_sat(sum_sc);
      cos_c           <= round_sat(sum_cc);
      sin_triple      <= s4_st;
      cos_triple      <= s4_ct;
      quadrant_triple <= s4_quad;
    end
  end

endmodule

/* rtl/qwsc_checker.sv */
// Port-level checks for the three-phase sine and cosine lookup, with its bind.
`timescale 1ns / 1ps
module qwsc_checker
  import qwsc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Reset leaves no result item behind
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item present after reset");

  // A stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // With the output side ready the pipeline always takes an item
  a_flow: assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while output side is ready");

  // Quadrant is one to four and rotated values never reach the negative limit
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[130:128] == 3'd1 || m_tdata[130:128] == 3'd2 ||
                  m_tdata[130:128] == 3'd3 || m_tdata[130:128] == 3'd4) &&
                 m_tdata[47:32] != 16'h8000 && m_tdata[63:48] != 16'h8000 &&
                 m_tdata[79:64] != 16'h8000 && m_tdata[95:80] != 16'h8000)
    else $error("result field out of range");

endmodule

bind quarter_wave_sincos_three_phase qwsc_checker u_qwsc_checker (.*);
